FILE: sv/i2cm_pkg.sv
// shared types, codes and constants of the i2c master byte controller
`default_nettype none

package i2cm_pkg;

  localparam int unsigned HalfPeriodW = 16;
  localparam int unsigned StepW       = 5;
  localparam logic [StepW-1:0] ByteSteps  = 5'd18;
  localparam logic [StepW-1:0] StartSteps = 5'd3;
  localparam logic [StepW-1:0] StopSteps  = 5'd2;
  localparam logic [StepW-1:0] AckStep    = 5'd16;
  localparam logic [HalfPeriodW-1:0] HalfPeriodRst = 16'd1;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef struct packed {
    logic       cmd_valid;
    cmd_e       func;
    logic [7:0] data;
    logic       rw_bit;
    logic       send_ack;
    logic       sda_in;
  } tick_item_t;

  function automatic logic [StepW-1:0] step_count(cmd_e cmd);
    logic [StepW-1:0] n;
    unique case (cmd)
      CMD_START: n = StartSteps;
      CMD_STOP:  n = StopSteps;
      default:   n = ByteSteps;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: sv/i2cm_if.sv
// handshake channels: tick item in and pin/status item out
`default_nettype none

interface i2cm_cmd_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [1:0] func;
  logic [7:0] data;
  logic       rw_bit;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, cmd_valid, func, data, rw_bit, send_ack, sda_in,
                  input ready);
  modport sink (input valid, cmd_valid, func, data, rw_bit, send_ack, sda_in,
                output ready);
endinterface

interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       nack_seen;

  modport source (output valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                  nack_seen, input ready);
  modport sink (input valid, scl_level, sda_release, busy_res, done_res, rx_byte,
                nack_seen, output ready);
endinterface

`default_nettype wire

FILE: sv/i2cm_in_reg.sv
// input register stage for tick items
`default_nettype none

module i2cm_in_reg
  import i2cm_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  i2cm_cmd_if.sink    cmd_i,
  input  wire         take_i,
  output logic        item_valid_o,
  output tick_item_t  item_o
);

  logic       valid_q, valid_d;
  tick_item_t item_q;
  logic       load;

  assign cmd_i.ready = !valid_q || take_i;
  assign load        = cmd_i.valid && cmd_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.cmd_valid <= cmd_i.cmd_valid;
      item_q.func      <= cmd_e'(cmd_i.func);
      item_q.data      <= cmd_i.data;
      item_q.rw_bit    <= cmd_i.rw_bit;
      item_q.send_ack  <= cmd_i.send_ack;
      item_q.sda_in    <= cmd_i.sda_in;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

FILE: sv/i2cm_engine.sv
// bus sequencer state and result register, one tick per cycle while the result is taken
`default_nettype none

module i2cm_engine
  import i2cm_pkg::*;
(
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire [HalfPeriodW-1:0]  cfg_wdata_i,
  input  wire                    item_valid_i,
  input  tick_item_t             item_i,
  output logic                   take_o,
  i2cm_res_if.source             res_o
);

  logic [HalfPeriodW-1:0] hp_q;
  cmd_e                   cmd_q, cmd_d;
  logic                   running_q, running_d;
  logic [StepW-1:0]       step_q, step_d;
  logic [HalfPeriodW-1:0] tick_q, tick_d;
  logic [7:0]             shift_q, shift_d;
  logic                   ack_q, ack_d;
  logic                   nack_q, nack_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic [7:0]             rx_q, rx_d;
  logic                   done_d;
  logic                   res_valid_q, res_valid_d;
  logic                   res_done_q;

  logic                   fire;
  logic                   act;
  logic [StepW-1:0]       k;
  logic [HalfPeriodW-1:0] tick_inc;
  logic [StepW-1:0]       step_inc;

  assign take_o   = !res_valid_q || res_o.ready;
  assign fire     = item_valid_i && take_o;
  assign tick_inc = tick_q + HalfPeriodW'(1);
  assign step_inc = step_q + StepW'(1);

  always_comb begin
    cmd_d     = cmd_q;
    running_d = running_q;
    step_d    = step_q;
    tick_d    = tick_q;
    shift_d   = shift_q;
    ack_d     = ack_q;
    nack_d    = nack_q;
    scl_d     = scl_q;
    sda_d     = sda_q;
    rx_d      = rx_q;
    done_d    = 1'b0;
    act       = 1'b0;
    k         = '0;

    if (fire) begin
      if (running_q) begin
        tick_d = tick_inc;
        if (tick_inc >= hp_q) begin
          tick_d = '0;
          if (step_inc >= step_count(cmd_q)) begin
            running_d = 1'b0;
            done_d    = 1'b1;
            step_d    = '0;
            if (cmd_q == CMD_READ) begin
              rx_d = shift_q;
              if (ack_q) begin
                sda_d = 1'b1;
              end
            end
          end else begin
            step_d = step_inc;
            act    = 1'b1;
            k      = step_inc;
          end
        end
      end else if (item_i.cmd_valid) begin
        cmd_d     = item_i.func;
        running_d = 1'b1;
        step_d    = '0;
        tick_d    = '0;
        ack_d     = item_i.send_ack;
        shift_d   = (item_i.func == CMD_WRITE) ? (item_i.data | {7'd0, item_i.rw_bit})
                                               : 8'd0;
        act       = 1'b1;
      end
    end

    if (act) begin
      unique case (cmd_d)
        CMD_START: begin
          if (k == 5'd0) begin
            sda_d = 1'b1;
            scl_d = 1'b1;
          end else if (k == 5'd1) begin
            sda_d = 1'b0;
          end else begin
            scl_d = 1'b0;
          end
        end
        CMD_STOP: begin
          if (k == 5'd0) begin
            sda_d = 1'b0;
            scl_d = 1'b1;
          end else begin
            sda_d = 1'b1;
          end
        end
        CMD_WRITE: begin
          if (k < AckStep) begin
            if (!k[0]) begin
              sda_d = shift_d[7];
              scl_d = 1'b1;
            end else begin
              scl_d   = 1'b0;
              shift_d = {shift_d[6:0], 1'b0};
            end
          end else if (k == AckStep) begin
            sda_d = 1'b1;
            scl_d = 1'b1;
          end else begin
            nack_d = item_i.sda_in;
            scl_d  = 1'b0;
          end
        end
        CMD_READ: begin
          if (k < AckStep) begin
            if (!k[0]) begin
              sda_d = 1'b1;
              scl_d = 1'b1;
            end else begin
              shift_d = {shift_d[6:0], item_i.sda_in};
              scl_d   = 1'b0;
            end
          end else if (k == AckStep) begin
            sda_d = !ack_d;
            scl_d = 1'b1;
          end else begin
            scl_d = 1'b0;
          end
        end
        default: begin
          scl_d = scl_q;
        end
      endcase
    end

    res_valid_d = res_valid_q;
    if (fire) begin
      res_valid_d = 1'b1;
    end else if (res_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q        <= HalfPeriodRst;
      cmd_q       <= CMD_START;
      running_q   <= 1'b0;
      step_q      <= '0;
      tick_q      <= '0;
      shift_q     <= '0;
      ack_q       <= 1'b0;
      nack_q      <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      rx_q        <= '0;
      res_valid_q <= 1'b0;
      res_done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hp_q <= cfg_wdata_i;
      end
      cmd_q       <= cmd_d;
      running_q   <= running_d;
      step_q      <= step_d;
      tick_q      <= tick_d;
      shift_q     <= shift_d;
      ack_q       <= ack_d;
      nack_q      <= nack_d;
      scl_q       <= scl_d;
      sda_q       <= sda_d;
      rx_q        <= rx_d;
      res_valid_q <= res_valid_d;
      if (fire) begin
        res_done_q <= done_d;
      end
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.scl_level   = scl_q;
  assign res_o.sda_release = sda_q;
  assign res_o.busy_res    = running_q;
  assign res_o.done_res    = res_done_q;
  assign res_o.rx_byte     = rx_q;
  assign res_o.nack_seen   = nack_q;

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_done_q |-> !running_q)
    else $error("done item shows busy");

  a_idle_step_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (step_q == '0))
    else $error("step index left nonzero while idle");

  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (step_q < step_count(cmd_q)))
    else $error("step index past end of command");

  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && done_d) |=> (!running_q && res_done_q))
    else $error("done without ending the command");

endmodule

`default_nettype wire

FILE: sv/i2c_master_byte_controller.sv
// top level of the tick-driven i2c master byte controller
//
//   channel   dir  handshake        payload
//   cmd_i     in   valid/ready      cmd_valid func data rw_bit send_ack sda_in
//   res_o     out  valid/ready      scl_level sda_release busy_res done_res
//                                   rx_byte nack_seen
//   cfg       in   cfg_we_i         cfg_wdata_i = half_period
//
// one item in and one item out per cycle while results are taken; each item passes
// the input register, then the sequencer plus result register
// a stalled result holds the sequencer and backs up into the input register
// reset: pins released, idle, half_period 1
`default_nettype none

module i2c_master_byte_controller
  import i2cm_pkg::*;
(
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire [HalfPeriodW-1:0] cfg_wdata_i,
  i2cm_cmd_if.sink              cmd_i,
  i2cm_res_if.source            res_o
);

  logic       item_valid;
  tick_item_t item;
  logic       take;

  i2cm_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  i2cm_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .res_o        (res_o)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// self-checking testbench of the tick-driven i2c master byte controller
`default_nettype none

module testbench;
  import i2cm_pkg::*;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       nack;
  } pin_status_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [HalfPeriodW-1:0] cfg_wdata_i;
  bit                     steady;
  int                     errors;
  int                     tick_total;
  int                     cmd_total;
  int                     done_seen;

  i2cm_cmd_if cmd_ch ();
  i2cm_res_if res_ch ();

  i2c_master_byte_controller dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_ch),
    .res_o       (res_ch)
  );

  // bus master model state
  logic [15:0] hp_m;
  cmd_e        cmd_m;
  logic        run_m;
  logic [4:0]  step_m;
  logic [15:0] wait_m;
  logic [7:0]  shreg_m;
  logic        ackc_m;
  logic        nack_m;
  logic        scl_m;
  logic        sda_m;
  logic [7:0]  rxh_m;

  pin_status_t pin_status_q[$];

  always #1 clk_i = ~clk_i;

  function automatic void drive_phase(input logic [4:0] k, input logic sda_line);
    case (cmd_m)
      CMD_START: begin
        if (k == 5'd0) begin
          sda_m = 1'b1;
          scl_m = 1'b1;
        end else if (k == 5'd1) begin
          sda_m = 1'b0;
        end else begin
          scl_m = 1'b0;
        end
      end
      CMD_STOP: begin
        if (k == 5'd0) begin
          sda_m = 1'b0;
          scl_m = 1'b1;
        end else begin
          sda_m = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (k < AckStep) begin
          if (!k[0]) begin
            sda_m = shreg_m[7];
            scl_m = 1'b1;
          end else begin
            scl_m   = 1'b0;
            shreg_m = shreg_m << 1;
          end
        end else if (k == AckStep) begin
          sda_m = 1'b1;
          scl_m = 1'b1;
        end else begin
          nack_m = sda_line;
          scl_m  = 1'b0;
        end
      end
      default: begin
        if (k < AckStep) begin
          if (!k[0]) begin
            sda_m = 1'b1;
            scl_m = 1'b1;
          end else begin
            shreg_m = {shreg_m[6:0], sda_line};
            scl_m   = 1'b0;
          end
        end else if (k == AckStep) begin
          sda_m = ~ackc_m;
          scl_m = 1'b1;
        end else begin
          scl_m = 1'b0;
        end
      end
    endcase
  endfunction

  function automatic pin_status_t step_master(input logic cv, input cmd_e f,
                                              input logic [7:0] d, input logic rw,
                                              input logic ack, input logic sda_line);
    logic       done;
    logic [4:0] last;
    done = 1'b0;
    if (run_m) begin
      wait_m = wait_m + 16'd1;
      if (wait_m >= hp_m) begin
        wait_m = '0;
        step_m = step_m + 5'd1;
        last = (cmd_m == CMD_START) ? StartSteps :
               (cmd_m == CMD_STOP) ? StopSteps : ByteSteps;
        if (step_m >= last) begin
          run_m  = 1'b0;
          done   = 1'b1;
          step_m = '0;
          if (cmd_m == CMD_READ) begin
            rxh_m = shreg_m;
            if (ackc_m) sda_m = 1'b1;
          end
        end else begin
          drive_phase(step_m, sda_line);
        end
      end
    end else if (cv) begin
      cmd_m   = f;
      run_m   = 1'b1;
      step_m  = '0;
      wait_m  = '0;
      ackc_m  = ack;
      shreg_m = (f == CMD_WRITE) ? (d | {7'd0, rw}) : 8'h00;
      drive_phase(5'd0, sda_line);
    end
    return '{scl_m, sda_m, run_m, done, rxh_m, nack_m};
  endfunction

  function automatic logic sda_level(input int mode);
    return (mode == 2) ? logic'($urandom_range(1)) : logic'(mode[0]);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] exp_v,
                                      input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s expected %0h actual %0h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // result side: random stalls, compare each item with the oldest prediction
  always @(negedge clk_i) res_ch.ready = steady || ($urandom_range(99) >= 13);

  always @(posedge clk_i) begin
    pin_status_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pin_status_q.size() == 0) begin
        $error("result item with nothing expected");
        errors++;
      end else begin
        want = pin_status_q.pop_front();
        if (want.done) done_seen++;
        check_field("scl_level", 8'(want.scl), 8'(res_ch.scl_level));
        check_field("sda_release", 8'(want.sda), 8'(res_ch.sda_release));
        check_field("busy_res", 8'(want.busy), 8'(res_ch.busy_res));
        check_field("done_res", 8'(want.done), 8'(res_ch.done_res));
        check_field("rx_byte", want.rx, res_ch.rx_byte);
        check_field("nack_seen", 8'(want.nack), 8'(res_ch.nack_seen));
      end
    end
  end

  task automatic send_tick(input logic cv, input cmd_e f, input logic [7:0] d,
                           input logic rw, input logic ack, input logic sda_line);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 13) begin
      cmd_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid     = 1'b1;
    cmd_ch.cmd_valid = cv;
    cmd_ch.func      = f;
    cmd_ch.data      = d;
    cmd_ch.rw_bit    = rw;
    cmd_ch.send_ack  = ack;
    cmd_ch.sda_in    = sda_line;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    pin_status_q.push_back(step_master(cv, f, d, rw, ack, sda_line));
    tick_total++;
  endtask

  task automatic idle_ticks(input int n);
    repeat (n) send_tick(1'b0, cmd_e'($urandom_range(3)), 8'($urandom_range(255)),
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
  endtask

  // offer a command on an idle tick, then tick until it finishes
  // noise_pct sets how often a new command is offered while busy
  task automatic run_command(input cmd_e f, input logic [7:0] d, input logic rw,
                             input logic ack, input int sda_mode, input int noise_pct);
    cmd_total++;
    send_tick(1'b1, f, d, rw, ack, sda_level(sda_mode));
    while (run_m) begin
      send_tick(1'($urandom_range(99) < noise_pct), cmd_e'($urandom_range(3)),
                8'($urandom_range(255)), 1'($urandom_range(1)),
                1'($urandom_range(1)), sda_level(sda_mode));
    end
  endtask

  task automatic random_command();
    int m;
    m = $urandom_range(5);
    run_command(cmd_e'($urandom_range(3)), 8'($urandom_range(255)),
                1'($urandom_range(1)), 1'($urandom_range(1)), (m > 2) ? 2 : m % 2, 20);
  endtask

  task automatic settle();
    @(negedge clk_i);
    cmd_ch.valid = 1'b0;
    while (pin_status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_half_period(input logic [15:0] v);
    settle();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    hp_m     = v;
  endtask

  task automatic test_directed();
    set_half_period(16'd1);
    idle_ticks(2);
    run_command(CMD_START, 8'h00, 1'b0, 1'b0, 1, 0);
    run_command(CMD_WRITE, 8'hA4, 1'b1, 1'b0, 0, 0);
    run_command(CMD_WRITE, 8'h00, 1'b0, 1'b1, 1, 0);
    run_command(CMD_WRITE, 8'hFE, 1'b1, 1'b0, 2, 0);
    run_command(CMD_READ, 8'h00, 1'b0, 1'b1, 1, 0);
    run_command(CMD_READ, 8'hFF, 1'b1, 1'b0, 0, 0);
    run_command(CMD_READ, 8'h3C, 1'b0, 1'b1, 2, 0);
    // restart straight after a read, then stop
    run_command(CMD_START, 8'hFF, 1'b1, 1'b1, 2, 0);
    run_command(CMD_STOP, 8'h55, 1'b0, 1'b0, 2, 0);
    idle_ticks(3);
    // commands offered on every busy tick are ignored
    run_command(CMD_WRITE, 8'h5A, 1'b0, 1'b0, 2, 100);
    run_command(CMD_READ, 8'hC3, 1'b1, 1'b0, 2, 100);
    run_command(CMD_START, 8'h81, 1'b0, 1'b1, 2, 100);
    run_command(CMD_STOP, 8'h7E, 1'b1, 1'b1, 2, 100);
  endtask

  task automatic test_half_periods();
    logic [15:0] hps[3];
    hps = '{16'd2, 16'd3, 16'd5};
    foreach (hps[i]) begin
      set_half_period(hps[i]);
      run_command(CMD_START, 8'h00, 1'b0, 1'b0, 2, 10);
      run_command(CMD_WRITE, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, 2, 10);
      run_command(CMD_READ, 8'h00, 1'b0, 1'($urandom_range(1)), 2, 10);
      run_command(CMD_STOP, 8'h00, 1'b0, 1'b0, 2, 10);
    end
  endtask

  task automatic test_random();
    logic [15:0] hps[5];
    int          first;
    hps = '{16'd1, 16'd1, 16'd2, 16'd3, 16'($urandom_range(4, 9))};
    foreach (hps[i]) begin
      set_half_period(hps[i]);
      steady = (i == 1);
      first  = tick_total;
      while (tick_total - first < 120) begin
        if ($urandom_range(2) == 0) idle_ticks($urandom_range(1, 3));
        random_command();
      end
      steady = 1'b0;
    end
  endtask

  task automatic test_max_half_period();
    set_half_period(16'hFFFF);
    cmd_total++;
    send_tick(1'b1, CMD_START, 8'h00, 1'b0, 1'b0, 1'b1);
    idle_ticks(40);
    // shorten the wait while the start still holds its first step
    set_half_period(16'd1);
    while (run_m) idle_ticks(1);
    // a zero half period waits one tick per step
    set_half_period(16'd0);
    run_command(CMD_WRITE, 8'h96, 1'b1, 1'b0, 2, 5);
    run_command(CMD_STOP, 8'h00, 1'b0, 1'b0, 2, 5);
    idle_ticks(2);
  endtask

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.cmd_valid = 1'b0;
    cmd_ch.func      = CMD_START;
    cmd_ch.data      = '0;
    cmd_ch.rw_bit    = 1'b0;
    cmd_ch.send_ack  = 1'b0;
    cmd_ch.sda_in    = 1'b0;
    res_ch.ready     = 1'b0;
    steady           = 1'b0;
    hp_m             = HalfPeriodRst;
    cmd_m            = CMD_START;
    run_m            = 1'b0;
    step_m           = '0;
    wait_m           = '0;
    shreg_m          = '0;
    ackc_m           = 1'b0;
    nack_m           = 1'b0;
    scl_m            = 1'b1;
    sda_m            = 1'b1;
    rxh_m            = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_half_periods();
    test_random();
    test_max_half_period();

    settle();
    repeat (6) @(posedge clk_i);
    $display("run covered %0d ticks and %0d commands, %0d of them completed",
             tick_total, cmd_total, done_seen);
    $display("half periods 0 to 65535, busy-time commands ignored, ack and nack both ways");
    if (errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("testbench: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
